// File: design/afr_pkg.sv
// afr_pkg: shared types, constants and helpers of the addressed frame receiver
// used by afr_front, afr_queue, afr_back and addressed_frame_receiver
`default_nettype none

package afr_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 256;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
    localparam int         HEADER_BYTES  = 6;
    localparam int         HEADER_WRITES = 8;
    localparam int         BEAT_W        = $clog2(HEADER_WRITES);

    // configuration register indexes
    localparam int         CFG_INDEX_W       = 1;
    localparam logic [0:0] CFG_OWN_ADDRESS   = 1'b0;
    localparam logic [0:0] CFG_GROUP_ADDRESS = 1'b1;
    localparam logic [7:0] OWN_ADDRESS_RESET   = 8'h01;
    localparam logic [7:0] GROUP_ADDRESS_RESET = 8'hFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CAUSE_PREAMBLE = 2'd0,
        CAUSE_LENGTH   = 2'd1,
        CAUSE_ADDRESS  = 2'd2
    } cause_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    // one classified item waiting for the back end
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  index;
        logic [7:0]  data;     // body byte or command byte
        logic        done;
        cause_t      cause;
        logic [15:0] length;
        logic [7:0]  address;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] write_index;
        logic [7:0] write_data;
        logic       frame_done;
        logic       frame_error;
        cause_t     error_cause;
        logic       last;
    } result_t;

    // rebuilt header byte for write beat k
    function automatic logic [7:0] header_byte(entry_t e, logic [BEAT_W-1:0] k);
        logic [7:0] b;
        case (k)
            3'd4:    b = e.length[7:0];
            3'd5:    b = e.length[15:8];
            3'd6:    b = e.address;
            3'd7:    b = e.data;
            default: b = PREAMBLE_BYTE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/afr_front.sv
// afr_front: byte parser, holds frame position, length, address and config
// depends on afr_pkg
`default_nettype none

module afr_front #(
    parameter int BUFFER_BYTES = afr_pkg::BUFFER_BYTES_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [afr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [7:0]                        cfg_data,
    input  wire logic                              accept,
    input  wire logic [7:0]                        rx_byte,
    output afr_pkg::entry_t                        push_entry,
    output logic                                   push
);

    localparam int         POS_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [16:0] LIMIT = 17'(BUFFER_BYTES);

    logic [POS_W-1:0] position_reg, position_next;
    logic [15:0]      body_length_reg, body_length_next;
    logic [7:0]       matched_address_reg, matched_address_next;
    logic [7:0]       own_address_reg, group_address_reg;

    logic [16:0] pos_ext;
    logic [15:0] length_full;

    assign pos_ext     = 17'(position_reg);
    assign length_full = {rx_byte, body_length_reg[7:0]};

    always_comb
    begin
        position_next        = position_reg;
        body_length_next     = body_length_reg;
        matched_address_next = matched_address_reg;
        push                 = 1'b0;
        push_entry           = '0;
        push_entry.length    = body_length_reg;
        push_entry.address   = matched_address_reg;
        push_entry.data      = rx_byte;
        push_entry.index     = pos_ext[7:0];
        if (accept)
        begin
            if (pos_ext < 17'd4)
            begin
                if (rx_byte != afr_pkg::PREAMBLE_BYTE)
                begin
                    push             = 1'b1;
                    push_entry.kind  = afr_pkg::KIND_ERROR;
                    push_entry.cause = afr_pkg::CAUSE_PREAMBLE;
                end
                else
                begin
                    position_next = position_reg + 1'b1;
                end
            end
            else if (pos_ext == 17'd4)
            begin
                body_length_next = {8'd0, rx_byte};
                position_next    = position_reg + 1'b1;
            end
            else if (pos_ext == 17'd5)
            begin
                body_length_next = length_full;
                if (({1'b0, length_full} + 17'(afr_pkg::HEADER_BYTES)) > LIMIT)
                begin
                    push             = 1'b1;
                    push_entry.kind  = afr_pkg::KIND_ERROR;
                    push_entry.cause = afr_pkg::CAUSE_LENGTH;
                end
                else
                begin
                    position_next = position_reg + 1'b1;
                end
            end
            else if (pos_ext == 17'd6)
            begin
                if (rx_byte != own_address_reg && rx_byte != group_address_reg)
                begin
                    push             = 1'b1;
                    push_entry.kind  = afr_pkg::KIND_ERROR;
                    push_entry.cause = afr_pkg::CAUSE_ADDRESS;
                end
                else
                begin
                    matched_address_next = rx_byte;
                    position_next        = position_reg + 1'b1;
                end
            end
            else if (pos_ext == 17'd7)
            begin
                push            = 1'b1;
                push_entry.kind = afr_pkg::KIND_HEADER;
                position_next   = position_reg + 1'b1;
            end
            else if (pos_ext < LIMIT)
            begin
                push            = 1'b1;
                push_entry.kind = afr_pkg::KIND_BODY;
                if (pos_ext >= ({1'b0, body_length_reg} + 17'd5))
                begin
                    push_entry.done  = 1'b1;
                    position_next    = '0;
                    body_length_next = '0;
                end
                else
                begin
                    position_next = position_reg + 1'b1;
                end
            end
            else
            begin
                push             = 1'b1;
                push_entry.kind  = afr_pkg::KIND_ERROR;
                push_entry.cause = afr_pkg::CAUSE_LENGTH;
            end
            if (push && push_entry.kind == afr_pkg::KIND_ERROR)
            begin
                position_next    = '0;
                body_length_next = '0;
            end
        end
        // fields that only the header or body kinds carry
        if (push_entry.kind == afr_pkg::KIND_ERROR)
        begin
            push_entry.data  = '0;
            push_entry.index = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg        <= '0;
            body_length_reg     <= '0;
            matched_address_reg <= '0;
            own_address_reg     <= afr_pkg::OWN_ADDRESS_RESET;
            group_address_reg   <= afr_pkg::GROUP_ADDRESS_RESET;
        end
        else
        begin
            position_reg        <= position_next;
            body_length_reg     <= body_length_next;
            matched_address_reg <= matched_address_next;
            if (cfg_write && cfg_index == afr_pkg::CFG_OWN_ADDRESS)
                own_address_reg <= cfg_data;
            if (cfg_write && cfg_index == afr_pkg::CFG_GROUP_ADDRESS)
                group_address_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire

// File: design/afr_queue.sv
// afr_queue: short fifo of classified items between front and back end
// depends on afr_pkg
`default_nettype none

module afr_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  afr_pkg::entry_t             push_entry,
    input  wire logic                   pop,
    output afr_pkg::entry_t             head,
    output afr_pkg::queue_status_t      status
);

    afr_pkg::entry_t                    entries_reg [afr_pkg::QUEUE_DEPTH];
    logic [afr_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [afr_pkg::QUEUE_CNT_W-1:0]    count_reg, count_next;
    logic                               do_push, do_pop;

    assign status.full  = (count_reg == afr_pkg::QUEUE_CNT_W'(afr_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// File: design/afr_back.sv
// afr_back: expands queued items into result items, one per cycle while out_stall is low
// depends on afr_pkg
`default_nettype none

module afr_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  afr_pkg::entry_t             head,
    input  afr_pkg::queue_status_t      status,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output afr_pkg::result_t            result
);

    afr_pkg::entry_t                hold_reg, hold_next;
    logic [afr_pkg::BEAT_W-1:0]     beat_reg, beat_next;
    logic                           busy_reg, busy_next;
    logic                           valid_reg, valid_next;
    afr_pkg::result_t               result_reg, result_next;
    logic                           advance;

    assign advance   = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        hold_next   = hold_reg;
        beat_next   = beat_reg;
        busy_next   = busy_reg;
        valid_next  = valid_reg;
        result_next = result_reg;
        pop         = 1'b0;
        if (advance)
        begin
            valid_next  = 1'b0;
            result_next = '0;
            if (busy_reg)
            begin
                // rest of a header rebuild
                valid_next              = 1'b1;
                result_next.write_valid = 1'b1;
                result_next.write_index = 8'(beat_reg);
                result_next.write_data  = afr_pkg::header_byte(hold_reg, beat_reg);
                result_next.last        = (beat_reg == afr_pkg::BEAT_W'(afr_pkg::HEADER_WRITES - 1));
                beat_next               = beat_reg + 1'b1;
                busy_next               = !result_next.last;
            end
            else if (!status.empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                case (head.kind)
                    afr_pkg::KIND_HEADER:
                    begin
                        result_next.write_valid = 1'b1;
                        result_next.write_index = '0;
                        result_next.write_data  = afr_pkg::header_byte(head, '0);
                        hold_next               = head;
                        beat_next               = afr_pkg::BEAT_W'(1);
                        busy_next               = 1'b1;
                    end
                    afr_pkg::KIND_BODY:
                    begin
                        result_next.write_valid = 1'b1;
                        result_next.write_index = head.index;
                        result_next.write_data  = head.data;
                        result_next.frame_done  = head.done;
                        result_next.last        = 1'b1;
                    end
                    default:
                    begin
                        result_next.frame_error = 1'b1;
                        result_next.error_cause = head.cause;
                        result_next.last        = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg  <= '0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg  <= beat_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// File: design/addressed_frame_receiver.sv
// addressed_frame_receiver: top level, front parser, item queue and back end
// depends on afr_pkg, afr_front, afr_queue, afr_back
`default_nettype none

// Receives a serial byte stream one item at a time and tracks its place in a
// frame: four 0xFF preamble bytes, a little-endian body length, an address
// byte (own or group address) and a command byte. Silent header bytes give no
// result; the command byte gives eight buffer writes that rebuild positions
// 0 to 7, and each body byte gives one write at its position, the last one
// flagged frame_done. A violation gives one result with frame_error and a
// cause, after which parsing restarts at position 0. An input item is taken
// in every cycle while the two-entry item queue has room; the back end emits
// one result per cycle while out_stall is low, so a body or error byte gives
// one result and a command byte eight. The output register sits behind the
// back end, so a stalled result does not hold up parsing until the queue fills.
// Configuration writes should be made only while the block is idle.

module addressed_frame_receiver #(
    parameter int BUFFER_BYTES = afr_pkg::BUFFER_BYTES_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_write,
    input  wire logic [afr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [7:0]                        cfg_data,
    // input items
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        rx_byte,
    // result items
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   write_valid,
    output logic [7:0]                             write_index,
    output logic [7:0]                             write_data,
    output logic                                   frame_done,
    output logic                                   frame_error,
    output logic [1:0]                             error_cause,
    output logic                                   last
);

    afr_pkg::entry_t        push_entry;
    afr_pkg::entry_t        head;
    afr_pkg::queue_status_t status;
    afr_pkg::result_t       result;
    logic                   push;
    logic                   pop;
    logic                   accept;

    // the front takes an item only while the queue can hold its outcome
    assign in_stall = status.full;
    assign accept   = in_valid && !in_stall;

    afr_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .push_entry (push_entry),
        .push       (push)
    );

    afr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    afr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .status    (status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // unpack the registered result onto its own ports
    assign write_valid = result.write_valid;
    assign write_index = result.write_index;
    assign write_data  = result.write_data;
    assign frame_done  = result.frame_done;
    assign frame_error = result.frame_error;
    assign error_cause = result.error_cause;
    assign last        = result.last;

    // an error item never writes the buffer and always closes its byte
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_error |-> !write_valid && last && !frame_done)
        else $error("error item carries a write or is not last");

    // frame completion comes only on a body write closing its byte
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> write_valid && last)
        else $error("frame_done without a final write");

    // only header beats 0 to 6 are non-final results
    a_header_beats: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> write_valid && write_index <= 8'd6)
        else $error("non-final result outside the header rebuild");

    // queue never overflows: a push happens only with room
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("item pushed into a full queue");

endmodule

`default_nettype wire

// File: tb/tb_addressed_frame_receiver.sv
`timescale 1ns / 1ps
// tb_addressed_frame_receiver: self-checking bench for the addressed frame receiver
// depends on afr_pkg and addressed_frame_receiver; frame parser mirrored in the bench

module tb_addressed_frame_receiver;

    localparam int BUFFER_BYTES    = afr_pkg::BUFFER_BYTES_DEFAULT;
    localparam int PREAMBLE_LEN    = 4;
    localparam int ITEMS_PER_PHASE = 14;
    localparam int HOLD_CYCLES     = 80;        // long receiver hold-off
    localparam int SETTLE_CYCLES   = 24;        // item queue plus output register, with margin
    localparam int DRAIN_LIMIT     = 5000;
    localparam int PRINT_LIMIT     = 40;
    localparam longint RUN_LIMIT_NS = 64'd6_000_000;

    // directed stimulus row: error rows carry their result typed in
    typedef struct {
        logic [7:0]       rx;
        bit               typed;
        afr_pkg::result_t want;
    } stim_row_t;

    // clock, reset and block inputs, all known from time zero
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [afr_pkg::CFG_INDEX_W-1:0] cfg_index = afr_pkg::CFG_OWN_ADDRESS;
    logic [7:0]                      cfg_data  = 8'h00;
    logic                            in_valid  = 1'b0;
    logic [7:0]                      rx_byte   = 8'h00;
    logic                            out_stall = 1'b0;

    // block outputs
    logic       in_stall;
    logic       out_valid;
    logic       write_valid;
    logic [7:0] write_index;
    logic [7:0] write_data;
    logic       frame_done;
    logic       frame_error;
    logic [1:0] error_cause;
    logic       last;

    // mirror of the parser state and of the two address registers
    int               frame_pos;
    logic [15:0]      frame_length;
    logic [7:0]       frame_addr;
    logic [7:0]       node_addr;
    logic [7:0]       multicast_addr;
    afr_pkg::result_t step_out [afr_pkg::HEADER_WRITES];

    afr_pkg::result_t frame_results_due [$];
    stim_row_t        directed_rows [$];

    int  mismatches      = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  frames_closed   = 0;
    int  frames_rejected = 0;
    bit  hold_off_now    = 1'b0;

    addressed_frame_receiver #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_valid (write_valid),
        .write_index (write_index),
        .write_data  (write_data),
        .frame_done  (frame_done),
        .frame_error (frame_error),
        .error_cause (error_cause),
        .last        (last)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // frame parser mirror
    // ------------------------------------------------------------------

    function automatic afr_pkg::result_t make_result(bit wv, logic [7:0] idx,
                                                     logic [7:0] data, bit done, bit err,
                                                     afr_pkg::cause_t cause, bit lst);
        afr_pkg::result_t r;
        r.write_valid = wv;
        r.write_index = idx;
        r.write_data  = data;
        r.frame_done  = done;
        r.frame_error = err;
        r.error_cause = cause;
        r.last        = lst;
        return r;
    endfunction

    // rejected frame: one result, parser back to the start, address kept
    function automatic int reject_frame(afr_pkg::cause_t cause);
        frame_pos    = 0;
        frame_length = '0;
        step_out[0]  = make_result(1'b0, 8'h00, 8'h00, 1'b0, 1'b1, cause, 1'b1);
        return 1;
    endfunction

    // advance the mirror by one received byte; results land in step_out
    function automatic int parse_rx_byte(logic [7:0] b);
        logic [7:0] hdr [afr_pkg::HEADER_WRITES];
        int         at;
        if (frame_pos < PREAMBLE_LEN)
        begin
            if (b != afr_pkg::PREAMBLE_BYTE)
                return reject_frame(afr_pkg::CAUSE_PREAMBLE);
            frame_pos++;
            return 0;
        end
        if (frame_pos == PREAMBLE_LEN)
        begin
            frame_length = {8'h00, b};
            frame_pos    = PREAMBLE_LEN + 1;
            return 0;
        end
        if (frame_pos == PREAMBLE_LEN + 1)
        begin
            frame_length[15:8] = b;
            if (int'(frame_length) + afr_pkg::HEADER_BYTES > BUFFER_BYTES)
                return reject_frame(afr_pkg::CAUSE_LENGTH);
            frame_pos = afr_pkg::HEADER_BYTES;
            return 0;
        end
        if (frame_pos == afr_pkg::HEADER_BYTES)
        begin
            if (b != node_addr && b != multicast_addr)
                return reject_frame(afr_pkg::CAUSE_ADDRESS);
            frame_addr = b;
            frame_pos  = afr_pkg::HEADER_BYTES + 1;
            return 0;
        end
        if (frame_pos == afr_pkg::HEADER_BYTES + 1)
        begin
            // command byte: whole header written back, cause field zero
            hdr = '{afr_pkg::PREAMBLE_BYTE, afr_pkg::PREAMBLE_BYTE,
                    afr_pkg::PREAMBLE_BYTE, afr_pkg::PREAMBLE_BYTE,
                    frame_length[7:0], frame_length[15:8], frame_addr, b};
            for (int k = 0; k < afr_pkg::HEADER_WRITES; k++)
                step_out[k] = make_result(1'b1, 8'(k), hdr[k], 1'b0, 1'b0,
                                          afr_pkg::CAUSE_PREAMBLE,
                                          k == afr_pkg::HEADER_WRITES - 1);
            frame_pos = afr_pkg::HEADER_WRITES;
            return afr_pkg::HEADER_WRITES;
        end
        if (frame_pos < BUFFER_BYTES)
        begin
            at = frame_pos;
            if (at >= int'(frame_length) + afr_pkg::HEADER_BYTES - 1)
            begin
                frame_pos    = 0;
                frame_length = '0;
                step_out[0]  = make_result(1'b1, 8'(at), b, 1'b1, 1'b0,
                                           afr_pkg::CAUSE_PREAMBLE, 1'b1);
                return 1;
            end
            frame_pos++;
            step_out[0] = make_result(1'b1, 8'(at), b, 1'b0, 1'b0,
                                      afr_pkg::CAUSE_PREAMBLE, 1'b1);
            return 1;
        end
        // past the buffer end, unreachable once the length check has passed
        return reject_frame(afr_pkg::CAUSE_LENGTH);
    endfunction

    // ------------------------------------------------------------------
    // directed table helpers
    // ------------------------------------------------------------------

    function automatic void add_row(logic [7:0] rx);
        stim_row_t r;
        r.rx    = rx;
        r.typed = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_error_row(logic [7:0] rx, afr_pkg::cause_t cause);
        stim_row_t r;
        r.rx    = rx;
        r.typed = 1'b1;
        r.want  = make_result(1'b0, 8'h00, 8'h00, 1'b0, 1'b1, cause, 1'b1);
        directed_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // reporting and result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want, input int seq);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s got %0h want %0h",
                                      seq, name, got, want));
    endtask

    // each accepted result against the oldest one still due
    always @(posedge clk)
    begin : result_check
        afr_pkg::result_t due;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (frame_results_due.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing due",
                                          results_checked));
            else
            begin
                due = frame_results_due.pop_front();
                check_field("write_valid", 8'(write_valid), 8'(due.write_valid), results_checked);
                check_field("write_index", write_index, due.write_index, results_checked);
                check_field("write_data",  write_data,  due.write_data,  results_checked);
                check_field("frame_done",  8'(frame_done),  8'(due.frame_done),  results_checked);
                check_field("frame_error", 8'(frame_error), 8'(due.frame_error), results_checked);
                check_field("error_cause", 8'(error_cause), 8'(due.error_cause), results_checked);
                check_field("last",        8'(last),        8'(due.last),        results_checked);
            end
            if (frame_done === 1'b1)
                frames_closed++;
            if (frame_error === 1'b1)
                frames_rejected++;
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // receiver side: random stalls, calm stretches and one long hold-off
    // ------------------------------------------------------------------

    initial
    begin : receiver_stall
        int hold_left;
        int calm_left;
        int busy_left;
        int r;
        hold_left = 0;
        calm_left = 0;
        busy_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_now)
            begin
                hold_off_now = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_stall <= 1'b0;
            end
            else if (busy_left > 0)
            begin
                busy_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                // mostly no stall, often a short one, now and then a long one or a calm stretch
                r = $urandom_range(0, 99);
                if (r < 8)
                    calm_left = $urandom_range(20, 60);
                else if (r < 36)
                    busy_left = $urandom_range(1, 3);
                else if (r < 40)
                    busy_left = $urandom_range(10, 30);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // sender gap: mostly none, some short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // offer one item from a falling edge, hold it until taken, predict on acceptance;
    // valid stays high when the next item follows without a gap
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input afr_pkg::result_t want);
        int gap;
        int n;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        n = parse_rx_byte(b);
        if (typed)
            frame_results_due.push_back(want);
        else
            for (int k = 0; k < n; k++)
                frame_results_due.push_back(step_out[k]);
        items_sent++;
        @(negedge clk);
    endtask

    // one frame: mostly well formed with random content, some broken or padded with noise
    task automatic send_random_frame();
        logic [7:0]       frame_bytes [$];
        logic [15:0]      length_word;
        logic [7:0]       addr;
        int               body_count;
        int               r;
        afr_pkg::result_t none;
        none = '0;
        r = $urandom_range(0, 99);
        length_word = (r < 85) ? 16'($urandom_range(0, 12)) : 16'($urandom_range(13, 40));
        r = $urandom_range(0, 99);
        if (r < 45)
            addr = node_addr;
        else if (r < 90)
            addr = multicast_addr;
        else
            addr = 8'($urandom_range(0, 255));
        repeat (PREAMBLE_LEN)
            frame_bytes.push_back(afr_pkg::PREAMBLE_BYTE);
        frame_bytes.push_back(length_word[7:0]);
        frame_bytes.push_back(length_word[15:8]);
        frame_bytes.push_back(addr);
        frame_bytes.push_back(8'($urandom_range(0, 255)));     // command
        // body runs from position 8 up to length plus 5, at least one byte
        body_count = (int'(length_word) > 3) ? int'(length_word) - 2 : 1;
        repeat (body_count)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        // broken frame: one byte replaced by noise
        if ($urandom_range(0, 99) < 15)
            frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        // stray noise ahead of the frame
        if ($urandom_range(0, 99) < 10)
            frame_bytes.push_front(8'($urandom_range(0, 255)));
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], 1'b0, none);
    endtask

    // address register write, only while the block is idle
    task automatic write_reg(input logic [afr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == afr_pkg::CFG_OWN_ADDRESS)
            node_addr = val;
        else
            multicast_addr = val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // drop valid, wait for every due result, then let silent items settle
    task automatic wait_until_idle();
        int spin;
        in_valid <= 1'b0;
        for (spin = 0; spin < DRAIN_LIMIT && frame_results_due.size() != 0; spin++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int phase_start;

        // mirror after reset
        frame_pos      = 0;
        frame_length   = '0;
        frame_addr     = 8'h00;
        node_addr      = afr_pkg::OWN_ADDRESS_RESET;
        multicast_addr = afr_pkg::GROUP_ADDRESS_RESET;

        // directed part, reset address values (own 01, group ff)
        add_error_row(8'h00, afr_pkg::CAUSE_PREAMBLE);   // junk at the first byte
        add_row(8'hFF);
        add_error_row(8'h7F, afr_pkg::CAUSE_PREAMBLE);   // preamble broken part way
        repeat (PREAMBLE_LEN) add_row(8'hFF);
        add_row(8'hFF);
        add_error_row(8'hFF, afr_pkg::CAUSE_LENGTH);     // largest length
        repeat (PREAMBLE_LEN) add_row(8'hFF);
        add_row(8'hFA);
        add_row(8'h00);                                  // length 250 just fits
        add_error_row(8'h02, afr_pkg::CAUSE_ADDRESS);    // neither own nor group
        repeat (PREAMBLE_LEN) add_row(8'hFF);
        add_row(8'h00);
        add_row(8'h00);                                  // empty body
        add_row(8'h01);                                  // own address
        add_row(8'hC3);                                  // command: header written back
        add_row(8'h5A);                                  // single byte closes the frame

        // reset held from time zero, released on a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

        // random phases, each under its own address setting
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_until_idle();
            case (phase)
                0:
                begin
                    write_reg(afr_pkg::CFG_OWN_ADDRESS, 8'h00);
                    write_reg(afr_pkg::CFG_GROUP_ADDRESS, 8'hFF);
                end
                1:
                begin
                    write_reg(afr_pkg::CFG_OWN_ADDRESS, 8'hFF);
                    write_reg(afr_pkg::CFG_GROUP_ADDRESS, 8'h00);
                end
                2:
                begin
                    write_reg(afr_pkg::CFG_OWN_ADDRESS, 8'($urandom_range(0, 255)));
                    write_reg(afr_pkg::CFG_GROUP_ADDRESS, 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    // own and group address the same
                    write_reg(afr_pkg::CFG_OWN_ADDRESS, 8'($urandom_range(0, 255)));
                    write_reg(afr_pkg::CFG_GROUP_ADDRESS, node_addr);
                end
            endcase
            // long receiver hold-off while items keep coming, so the queue fills
            if (phase == 1)
                hold_off_now = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
                send_random_frame();
        end

        wait_until_idle();
        if (frame_results_due.size() != 0)
            report_mismatch($sformatf("%0d results still due at the end",
                                      frame_results_due.size()));

        $display("run: %0d bytes received, %0d results checked under four address settings",
                 items_sent, results_checked);
        $display("run: %0d frames completed, %0d frames rejected, %0d mismatches",
                 frames_closed, frames_rejected, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin : run_limit
        #(RUN_LIMIT_NS);
        $display("run limit reached with %0d results still due", frame_results_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
